### rtl/lrupr_pkg.sv
// Package for the LRU page replacement block: state encoding and fixed widths.
// Used by lru_page_replacement and lrupr_chk; no dependencies.
`default_nettype none

package lrupr_pkg;

	localparam int unsigned CFG_WIDTH    = 5;
	localparam int unsigned TIME_WIDTH   = 32;
	localparam int unsigned PAGE_PORT_W  = 16;
	localparam int unsigned SLOT_PORT_W  = 4;
	localparam int unsigned FAULT_WIDTH  = 32;

	localparam logic [CFG_WIDTH-1:0] FRAMES_RESET = 5'd4;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} lrupr_state_t;

endpackage

`default_nettype wire

### rtl/lrupr_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the frame table ({page, last use}); depends on nothing.
`default_nettype none

module lrupr_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/lru_page_replacement.sv
// LRU page replacement unit: frame table in one synchronous RAM, scanned per request.
// Depends on lrupr_pkg and lrupr_ram.
// Sequence: a request is taken only while idle; the scan reads every active frame once
// through the single RAM read port, then the decide state writes the table and gives the
// result strobe for one cycle. busy stays high until that strobe, so one request at a time.
// Reset: arst_n clears control, frame count to 4, fill count, clock and fault total.
`default_nettype none

module lru_page_replacement #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_write,
	input  wire logic [lrupr_pkg::CFG_WIDTH-1:0]     cfg_data,
	// request
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]   page_number,
	input  wire logic                                last_reference,
	// result
	output logic                                     done,
	output logic                                     hit,
	output logic [lrupr_pkg::SLOT_PORT_W-1:0]        frame_slot,
	output logic                                     evicted,
	output logic [lrupr_pkg::PAGE_PORT_W-1:0]        evicted_page,
	output logic [lrupr_pkg::FAULT_WIDTH-1:0]        fault_count
);

	localparam int unsigned TW = lrupr_pkg::TIME_WIDTH;
	localparam int unsigned FW = lrupr_pkg::FAULT_WIDTH;
	localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	// counts run 0..MAX_FRAMES
	localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
	localparam int unsigned DW = PAGE_WIDTH + TW;

	lrupr_pkg::lrupr_state_t state_q;

	logic [lrupr_pkg::CFG_WIDTH-1:0] frames_q;
	logic [CW-1:0]                   n_q;        // active frame count for this request
	logic [CW-1:0]                   fill_q;     // frames filled since sequence start
	logic [TW-1:0]                   clock_q;    // reference clock, saturating
	logic [FW-1:0]                   fault_q;    // fault total, saturating

	logic [PAGE_WIDTH-1:0]           page_q;
	logic                            last_q;

	// scan: read issue side and compare side (RAM read is registered)
	logic [CW-1:0]                   rd_cnt_q;
	logic                            cmp_v_s1;
	logic [IW-1:0]                   cmp_idx_s1;

	logic                            hit_q;
	logic [IW-1:0]                   hit_idx_q;
	logic [IW-1:0]                   old_idx_q;
	logic [TW-1:0]                   old_time_q;
	logic [PAGE_WIDTH-1:0]           old_page_q;

	// RAM port signals
	logic                            rd_en;
	logic [DW-1:0]                   rd_data;
	logic [PAGE_WIDTH-1:0]           rd_page;
	logic [TW-1:0]                   rd_time;
	logic                            wr_en;

	// decision
	logic [IW-1:0]                   dec_slot;
	logic                            dec_evict;
	logic [FW-1:0]                   fault_next;
	logic                            scan_last;

	// width helpers
	logic [31:0]                     pn_ext;
	logic [31:0]                     frames_ext;
	logic [CW-1:0]                   n_calc;
	logic [31:0]                     slot_ext;
	logic [31:0]                     evp_ext;

	lrupr_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (dec_slot),
		.wdata ({page_q, clock_q}),
		.re    (rd_en),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rd_data)
	);

	assign busy = (state_q != lrupr_pkg::ST_IDLE);

	// page bits beyond PAGE_WIDTH are dropped, missing ones read as zero
	assign pn_ext = 32'(page_number);

	// frame count register: zero acts as one, beyond the build acts as the build
	always_comb begin
		frames_ext = 32'(frames_q);
		if (frames_ext == 32'd0) begin
			n_calc = CW'(1);
		end else if (frames_ext > 32'(MAX_FRAMES)) begin
			n_calc = CW'(MAX_FRAMES);
		end else begin
			n_calc = CW'(frames_ext);
		end
	end

	assign rd_en   = (state_q == lrupr_pkg::ST_SCAN) && (rd_cnt_q < n_q);
	assign rd_page = rd_data[TW +: PAGE_WIDTH];
	assign rd_time = rd_data[TW-1:0];
	assign scan_last = cmp_v_s1 && (CW'(cmp_idx_s1) == n_q - CW'(1));

	// hit refreshes its frame, miss fills the next free frame or evicts the oldest
	always_comb begin
		if (hit_q) begin
			dec_slot  = hit_idx_q;
			dec_evict = 1'b0;
		end else if (fill_q < n_q) begin
			dec_slot  = fill_q[IW-1:0];
			dec_evict = 1'b0;
		end else begin
			dec_slot  = old_idx_q;
			dec_evict = 1'b1;
		end
	end

	assign wr_en = (state_q == lrupr_pkg::ST_DECIDE);
	assign fault_next = (hit_q || (fault_q == '1)) ? fault_q : fault_q + FW'(1);

	assign slot_ext = 32'(dec_slot);
	assign evp_ext  = 32'(old_page_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lrupr_pkg::FRAMES_RESET;
		end else if (cfg_write) begin
			frames_q <= cfg_data;
		end
	end

	// sequencer and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lrupr_pkg::ST_IDLE;
			fill_q   <= '0;
			clock_q  <= '0;
			fault_q  <= '0;
			rd_cnt_q <= '0;
			cmp_v_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			done     <= 1'b0;
			cmp_v_s1 <= rd_en;
			case (state_q)
				lrupr_pkg::ST_IDLE: begin
					if (start) begin
						rd_cnt_q <= '0;
						state_q  <= lrupr_pkg::ST_SCAN;
					end
				end
				lrupr_pkg::ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (scan_last) begin
						state_q <= lrupr_pkg::ST_DECIDE;
					end
				end
				lrupr_pkg::ST_DECIDE: begin
					done    <= 1'b1;
					state_q <= lrupr_pkg::ST_IDLE;
					if (last_q) begin
						// sequence ends: table is dropped by resetting the fill count
						fill_q  <= '0;
						clock_q <= '0;
						fault_q <= '0;
					end else begin
						if (!hit_q && (fill_q < n_q)) begin
							fill_q <= fill_q + CW'(1);
						end
						if (clock_q != '1) begin
							clock_q <= clock_q + TW'(1);
						end
						fault_q <= fault_next;
					end
				end
				default: begin
					state_q <= lrupr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request capture, scan compare and result registers (payload, no reset)
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q[IW-1:0];
		if (state_q == lrupr_pkg::ST_IDLE && start) begin
			page_q <= pn_ext[PAGE_WIDTH-1:0];
			last_q <= last_reference;
			n_q    <= n_calc;
			hit_q  <= 1'b0;
		end
		if (state_q == lrupr_pkg::ST_SCAN && cmp_v_s1) begin
			// first filled frame holding the page wins
			if (!hit_q && (CW'(cmp_idx_s1) < fill_q) && (rd_page == page_q)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end
			// strict compare keeps the lowest index on ties
			if (cmp_idx_s1 == '0 || rd_time < old_time_q) begin
				old_idx_q  <= cmp_idx_s1;
				old_time_q <= rd_time;
				old_page_q <= rd_page;
			end
		end
		if (state_q == lrupr_pkg::ST_DECIDE) begin
			hit          <= hit_q;
			frame_slot   <= slot_ext[lrupr_pkg::SLOT_PORT_W-1:0];
			evicted      <= dec_evict;
			evicted_page <= dec_evict ? evp_ext[lrupr_pkg::PAGE_PORT_W-1:0] : '0;
			fault_count  <= fault_next;
		end
	end

endmodule

`default_nettype wire

### rtl/lrupr_chk.sv
// Port-level checker for lru_page_replacement, attached by the bind below.
// Depends on lrupr_pkg for port widths.
`default_nettype none

module lrupr_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic                                hit,
	input wire logic                                evicted,
	input wire logic [lrupr_pkg::PAGE_PORT_W-1:0]   evicted_page
);

	// a taken request keeps the block busy on the next cycle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// a result only follows busy cycles and returns the block to idle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe outside a request");

	// strobe lasts exactly one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// a hit never evicts, and no eviction reports a page
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && (hit || !evicted) |-> !evicted && evicted_page == '0)
		else $error("eviction reported with hit or stale evicted page");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.evicted      (evicted),
	.evicted_page (evicted_page)
);

`default_nettype wire

### tb/lrupr_chk.sv
`timescale 1ns / 100ps
// Scoreboard for lru_page_replacement: mirrors the frame table and checks every result.
// Depends on lrupr_pkg; watches the configuration, request and result ports only.
module lrupr_scoreboard (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [lrupr_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  wire logic                                start,
	input  wire logic                                busy,
	input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]   page_number,
	input  wire logic                                last_reference,
	input  wire logic                                done,
	input  wire logic                                hit,
	input  wire logic [lrupr_pkg::SLOT_PORT_W-1:0]   frame_slot,
	input  wire logic                                evicted,
	input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]   evicted_page,
	input  wire logic [lrupr_pkg::FAULT_WIDTH-1:0]   fault_count,
	output int unsigned                              pending_cnt,
	output int unsigned                              fail_cnt
);

	localparam int unsigned FRAMES       = 16;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic                              hit;
		logic [lrupr_pkg::SLOT_PORT_W-1:0] slot;
		logic                              evicted;
		logic [lrupr_pkg::PAGE_PORT_W-1:0] evicted_page;
		logic [lrupr_pkg::FAULT_WIDTH-1:0] faults;
	} page_outcome_t;

	// mirrored frame table
	logic [lrupr_pkg::PAGE_PORT_W-1:0] held_page [FRAMES];
	logic                              held_ok   [FRAMES];
	logic [lrupr_pkg::TIME_WIDTH-1:0]  used_at   [FRAMES];
	logic [lrupr_pkg::CFG_WIDTH-1:0]   frames_cfg;
	logic [4:0]                        frames_filled;
	logic [lrupr_pkg::TIME_WIDTH-1:0]  ref_tick;
	logic [lrupr_pkg::FAULT_WIDTH-1:0] fault_tally;

	page_outcome_t outcome_q [$];
	int unsigned   report_cnt;

	function automatic void clear_frames();
		for (int i = 0; i < FRAMES; i++) begin
			held_page[i] = '0;
			held_ok[i]   = 1'b0;
			used_at[i]   = '0;
		end
		frames_filled = '0;
		ref_tick      = '0;
		fault_tally   = '0;
	endfunction

	// one page reference against the mirrored table; returns its result
	function automatic page_outcome_t reference_page(
			input logic [lrupr_pkg::PAGE_PORT_W-1:0] page, input logic last);
		page_outcome_t res;
		int unsigned   n;
		int unsigned   victim;
		logic          found;
		if (frames_cfg == '0)
			n = 1;
		else if (int'(frames_cfg) > FRAMES)
			n = FRAMES;
		else
			n = int'(frames_cfg);
		res    = '0;
		found  = 1'b0;
		victim = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && held_ok[i] && held_page[i] == page) begin
				found  = 1'b1;
				victim = i;
			end
		end
		if (found) begin
			res.hit         = 1'b1;
			used_at[victim] = ref_tick;
		end else begin
			if (int'(frames_filled) < n) begin
				victim        = int'(frames_filled);
				frames_filled = frames_filled + 5'd1;
			end else begin
				// oldest use time, lowest index on ties
				victim = 0;
				for (int i = 1; i < n; i++)
					if (used_at[i] < used_at[victim])
						victim = i;
				res.evicted      = 1'b1;
				res.evicted_page = held_page[victim];
			end
			held_page[victim] = page;
			used_at[victim]   = ref_tick;
			held_ok[victim]   = 1'b1;
			if (fault_tally != '1)
				fault_tally = fault_tally + 1'b1;
		end
		res.slot   = lrupr_pkg::SLOT_PORT_W'(victim);
		res.faults = fault_tally;
		if (ref_tick != '1)
			ref_tick = ref_tick + 1'b1;
		if (last)
			clear_frames();
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_outcome_t want;
		page_outcome_t got;
		if (!arst_n) begin
			frames_cfg = lrupr_pkg::FRAMES_RESET;
			clear_frames();
			outcome_q.delete();
			fail_cnt   = 0;
			report_cnt = 0;
		end else begin
			if (done) begin
				got.hit          = hit;
				got.slot         = frame_slot;
				got.evicted      = evicted;
				got.evicted_page = evicted_page;
				got.faults       = fault_count;
				if (outcome_q.size() == 0) begin
					fail_cnt++;
					if (report_cnt < REPORT_LIMIT) begin
						report_cnt++;
						$display("%0t: result with no request outstanding: hit=%0b slot=%0d",
							$time, got.hit, got.slot);
					end
				end else begin
					want = outcome_q.pop_front();
					if (got != want) begin
						fail_cnt++;
						if (report_cnt < REPORT_LIMIT) begin
							report_cnt++;
							$display("%0t: mismatch exp hit=%0b slot=%0d ev=%0b %s",
								$time, want.hit, want.slot, want.evicted,
								$sformatf("ev_page=%h faults=%0d",
								want.evicted_page, want.faults));
							$display("%0t:          got hit=%0b slot=%0d ev=%0b %s",
								$time, got.hit, got.slot, got.evicted,
								$sformatf("ev_page=%h faults=%0d",
								got.evicted_page, got.faults));
						end
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(reference_page(page_number, last_reference));
			if (cfg_write)
				frames_cfg = cfg_data;
		end
		pending_cnt = outcome_q.size();
	end

endmodule

### tb/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
// Top testbench for lru_page_replacement: clock, reset, request stimulus, watchdog, verdict.
// Depends on lrupr_pkg, the lru_page_replacement block and the lrupr_scoreboard module.
module tb_lru_page_replacement;

	localparam int unsigned FRAMES          = 16;
	localparam int unsigned RANDOM_REQUESTS = 1500;
	// a request waits at most for one busy window plus a sender gap; config pauses are short
	localparam int unsigned IDLE_LIMIT      = 1000;
	localparam int unsigned DRAIN_CYCLES    = 40;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_write;
	logic [lrupr_pkg::CFG_WIDTH-1:0]   cfg_data;
	logic                              start;
	logic                              busy;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] page_number;
	logic                              last_reference;
	logic                              done;
	logic                              hit;
	logic [lrupr_pkg::SLOT_PORT_W-1:0] frame_slot;
	logic                              evicted;
	logic [lrupr_pkg::PAGE_PORT_W-1:0] evicted_page;
	logic [lrupr_pkg::FAULT_WIDTH-1:0] fault_count;

	int unsigned pending_cnt;
	int unsigned fail_cnt;
	int unsigned idle_cycles;
	int unsigned burst_left;
	int unsigned sent;

	lru_page_replacement #(
		.MAX_FRAMES (FRAMES),
		.PAGE_WIDTH (16)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.page_number    (page_number),
		.last_reference (last_reference),
		.done           (done),
		.hit            (hit),
		.frame_slot     (frame_slot),
		.evicted        (evicted),
		.evicted_page   (evicted_page),
		.fault_count    (fault_count)
	);

	lrupr_scoreboard u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.page_number    (page_number),
		.last_reference (last_reference),
		.done           (done),
		.hit            (hit),
		.frame_slot     (frame_slot),
		.evicted        (evicted),
		.evicted_page   (evicted_page),
		.fault_count    (fault_count),
		.pending_cnt    (pending_cnt),
		.fail_cnt       (fail_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any accepted request or result restarts the count. A hung block or a
	// lost result (scoreboard still waiting) runs it out.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[lru_page_replacement] ERROR");
			$finish;
		end
	end

	// Sender pacing: bursts of random length, random gaps. Long bursts give stretches
	// with back-to-back requests; short gaps land start at every point of the busy window.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start = 1'b0;
			gap   = $urandom_range(1, 20);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(0, 12);
		end
	endtask

	// Drive one request at a falling edge and hold it until the rising edge that takes it.
	// busy is stable across the low phase, so busy low here means the next edge accepts.
	task automatic issue_reference(input logic [lrupr_pkg::PAGE_PORT_W-1:0] page,
			input logic last);
		page_number    = page;
		last_reference = last;
		start          = 1'b1;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		sent++;
		pace_sender();
	endtask

	// Frame count is only changed with nothing in flight: drain every outstanding request,
	// give the block a few spare cycles, then write the register.
	task automatic set_frames(input logic [lrupr_pkg::CFG_WIDTH-1:0] value);
		start = 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_data  = value;
		cfg_write = 1'b1;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	initial begin
		int unsigned                       phase_len;
		int unsigned                       pool_size;
		int unsigned                       n_eff;
		int unsigned                       phase;
		logic [lrupr_pkg::PAGE_PORT_W-1:0] pool_base;
		logic [lrupr_pkg::PAGE_PORT_W-1:0] page;
		logic [lrupr_pkg::CFG_WIDTH-1:0]   frames_sel;
		logic                              last;

		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_data       = '0;
		start          = 1'b0;
		page_number    = '0;
		last_reference = 1'b0;
		burst_left     = 0;
		sent           = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// reset count of 4 frames: fill in order, a hit, LRU evictions, page extremes
		issue_reference(16'h0000, 1'b0);
		issue_reference(16'hFFFF, 1'b0);
		issue_reference(16'h0000, 1'b0);  // hit refreshes frame 0
		issue_reference(16'h0001, 1'b0);
		issue_reference(16'h0002, 1'b0);
		issue_reference(16'h0003, 1'b0);  // table full: oldest is the 0xFFFF frame
		issue_reference(16'hFFFF, 1'b0);  // faults back in, evicts the next oldest
		issue_reference(16'h0003, 1'b1);  // hit and end of sequence: table clears

		// count of 0 behaves as a single frame
		set_frames(5'd0);
		issue_reference(16'h5555, 1'b0);
		issue_reference(16'h5555, 1'b0);
		issue_reference(16'hAAAA, 1'b0);
		issue_reference(16'h5555, 1'b1);

		// count grows mid-sequence: fill resumes into the new frame
		set_frames(5'd2);
		issue_reference(16'h0007, 1'b0);
		issue_reference(16'h0008, 1'b0);
		issue_reference(16'h0009, 1'b0);
		set_frames(5'd3);
		issue_reference(16'h000A, 1'b0);
		issue_reference(16'h0008, 1'b0);
		issue_reference(16'h000B, 1'b0);

		// count shrinks mid-sequence: frames above it are not searched, page 10 misses
		set_frames(5'd1);
		issue_reference(16'h0008, 1'b0);
		issue_reference(16'h000A, 1'b1);

		// count above the built size behaves as 16
		set_frames(5'd31);
		issue_reference(16'h8000, 1'b1);

		// ---- random part ----
		// Each phase picks a frame count and a small page pool so that hits and evictions
		// both occur often; a few fully random pages toggle every page bit. Phases end
		// with or without a last reference, so count changes also fall mid-sequence.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_REQUESTS) begin
			if (phase == 0)
				frames_sel = 5'd16;
			else begin
				case ($urandom_range(0, 5))
					0: frames_sel = 5'd1;
					1: frames_sel = 5'd16;
					2: frames_sel = 5'($urandom_range(17, 31));
					3: frames_sel = 5'd0;
					4: frames_sel = 5'($urandom_range(0, 31));
					default: frames_sel = 5'($urandom_range(2, 8));
				endcase
			end
			set_frames(frames_sel);
			if (frames_sel == '0)
				n_eff = 1;
			else if (int'(frames_sel) > FRAMES)
				n_eff = FRAMES;
			else
				n_eff = int'(frames_sel);
			pool_size = $urandom_range(1, n_eff + n_eff / 2 + 2);
			pool_base = 16'($urandom);
			phase_len = $urandom_range(20, 120);
			for (int k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 9) == 0)
					page = 16'($urandom);
				else
					page = pool_base + 16'($urandom_range(0, pool_size - 1));
				if (k == phase_len - 1)
					last = 1'($urandom_range(0, 1));
				else
					last = ($urandom_range(0, 39) == 0);
				issue_reference(page, last);
			end
			phase++;
		end

		// ---- wind-down ----
		start = 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("[lru_page_replacement] OK");
		else
			$display("[lru_page_replacement] ERROR");
		$finish;
	end

endmodule
